### rtl/fdcbe_pkg.sv
package fdcbe_pkg;

  localparam int CHUNKS_PER_LINE = 32;
  localparam int LINES_PER_FRAME = 192;
  localparam int STORE_DEPTH     = CHUNKS_PER_LINE * LINES_PER_FRAME;
  localparam int CHUNK_W         = (CHUNKS_PER_LINE > 1) ? $clog2(CHUNKS_PER_LINE) : 1;
  localparam int LINE_W          = (LINES_PER_FRAME > 1) ? $clog2(LINES_PER_FRAME) : 1;
  localparam int ADDR_W          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int MASK_W          = 32;
  localparam int PIX_PER_CHUNK   = 8;

  localparam logic [7:0] THRESHOLD_RESET = 8'd127;
  localparam logic [7:0] LINE_EMPTY      = 8'd0;
  localparam logic [7:0] LINE_BITMAP     = 8'd1;

  typedef enum logic [1:0] {
    KIND_TYPE = 2'd0,
    KIND_FLAG = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_TYPE,
    ST_FLAG,
    ST_DATA
  } state_t;

  typedef struct packed {
    logic [7:0] red_0;
    logic [7:0] red_1;
    logic [7:0] red_2;
    logic [7:0] red_3;
    logic [7:0] red_4;
    logic [7:0] red_5;
    logic [7:0] red_6;
    logic [7:0] red_7;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic [7:0] line_number;
    logic       last;
  } out_item_t;

endpackage

### rtl/frame_diff_chunk_bitmap_encoder.sv
// Mid-line item: accepted in idle, stored and diffed in the next; in_ready stays low until then.
// Last item of a line: stored, then 1 type record, and if any chunk changed, 4 flag bytes
// and a scan of up to 32 chunk slots at one slot a cycle, each transfer waiting on out_ready.
// Output register lets the final result wait while the next item is taken.
// Reset (rst_n low, synchronous): sequencer idle, position and mask zero, first frame
// set, threshold 127. Frame store is not cleared; its contents are first used in the second frame.
module frame_diff_chunk_bitmap_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fdcbe_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fdcbe_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import fdcbe_pkg::*;

  state_t                 state_r, state_nxt;
  logic [7:0]             thresh_r;
  logic [7:0]             cur_r, cur_nxt;
  logic [MASK_W-1:0]      mask_r, mask_nxt;
  logic [MASK_W-1:0]      scan_r, scan_nxt;
  logic [CHUNK_W-1:0]     chunk_r, chunk_nxt;
  logic [LINE_W-1:0]      line_r, line_nxt;
  logic                   first_r, first_nxt;
  logic [1:0]             flag_cnt_r, flag_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic [7:0]             frame_mem [STORE_DEPTH];
  logic [7:0]             chunk_mem [CHUNKS_PER_LINE];
  logic [7:0]             prev_rd_r;
  logic [7:0]             chunk_rd_r;
  logic [ADDR_W-1:0]      addr;
  logic [7:0]             diff;
  logic                   store_we;
  logic                   out_free;
  logic                   in_xfer;
  logic [7:0]             red [PIX_PER_CHUNK];
  logic [7:0]             flag_word;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign addr = ADDR_W'(line_r * CHUNKS_PER_LINE) + ADDR_W'(chunk_r);
  assign diff = first_r ? cur_r : (cur_r ^ prev_rd_r);
  assign flag_word = 8'(mask_r >> {~flag_cnt_r, 3'b000});

  assign red[0] = in_data.red_0;
  assign red[1] = in_data.red_1;
  assign red[2] = in_data.red_2;
  assign red[3] = in_data.red_3;
  assign red[4] = in_data.red_4;
  assign red[5] = in_data.red_5;
  assign red[6] = in_data.red_6;
  assign red[7] = in_data.red_7;

  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_mem[addr]    <= cur_r;
      chunk_mem[chunk_r] <= diff;
    end
    prev_rd_r  <= frame_mem[addr];
    chunk_rd_r <= chunk_mem[chunk_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thresh_r    <= THRESHOLD_RESET;
      mask_r      <= '0;
      chunk_r     <= '0;
      line_r      <= '0;
      first_r     <= 1'b1;
      flag_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      chunk_r     <= chunk_nxt;
      line_r      <= line_nxt;
      first_r     <= first_nxt;
      flag_cnt_r  <= flag_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thresh_r <= cfg_data;
      end
    end
    cur_r      <= cur_nxt;
    scan_r     <= scan_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    mask_nxt      = mask_r;
    scan_nxt      = scan_r;
    chunk_nxt     = chunk_r;
    line_nxt      = line_r;
    first_nxt     = first_r;
    flag_cnt_nxt  = flag_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    store_we      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          for (int p = 0; p < PIX_PER_CHUNK; p++) begin
            cur_nxt[p] = (red[p] <= thresh_r);
          end
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        store_we = 1'b1;
        if (diff != 8'd0) begin
          mask_nxt[MASK_W-1-int'(chunk_r)] = 1'b1;
        end
        if (int'(chunk_r) == CHUNKS_PER_LINE - 1) begin
          state_nxt = ST_TYPE;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_TYPE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_TYPE;
          out_data_nxt.line_number = 8'(line_r);
          if (mask_r == '0) begin
            out_data_nxt.out_byte = LINE_EMPTY;
            out_data_nxt.last     = 1'b1;
            state_nxt             = ST_IDLE;
            chunk_nxt             = '0;
            if (int'(line_r) == LINES_PER_FRAME - 1) begin
              line_nxt  = '0;
              first_nxt = 1'b0;
            end else begin
              line_nxt = line_r + 1'b1;
            end
          end else begin
            out_data_nxt.out_byte = LINE_BITMAP;
            out_data_nxt.last     = 1'b0;
            flag_cnt_nxt          = '0;
            state_nxt             = ST_FLAG;
          end
        end
      end
      ST_FLAG: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_FLAG;
          out_data_nxt.line_number = 8'(line_r);
          out_data_nxt.out_byte    = flag_word;
          out_data_nxt.last        = 1'b0;
          flag_cnt_nxt             = flag_cnt_r + 1'b1;
          if (flag_cnt_r == 2'd3) begin
            scan_nxt  = mask_r;
            chunk_nxt = '0;
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (!scan_r[MASK_W-1] || out_free) begin
          if (scan_r[MASK_W-1]) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.kind        = KIND_DATA;
            out_data_nxt.line_number = 8'(line_r);
            out_data_nxt.out_byte    = chunk_rd_r;
            out_data_nxt.last        = (scan_r[MASK_W-2:0] == '0);
          end
          if (scan_r[MASK_W-1] && scan_r[MASK_W-2:0] == '0) begin
            state_nxt = ST_IDLE;
            mask_nxt  = '0;
            chunk_nxt = '0;
            if (int'(line_r) == LINES_PER_FRAME - 1) begin
              line_nxt  = '0;
              first_nxt = 1'b0;
            end else begin
              line_nxt = line_r + 1'b1;
            end
          end else begin
            scan_nxt  = scan_r << 1;
            chunk_nxt = chunk_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_scan_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> (scan_r != '0))
    else $error("chunk scan running with no used chunk left");

  a_update_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> $past(in_valid && in_ready))
    else $error("store update without an input transfer");

  a_line_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(line_r) < LINES_PER_FRAME)
    else $error("line position out of range");

  a_mask_clear_at_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && chunk_r == '0) |-> (mask_r == '0))
    else $error("used mask not cleared at start of line");
`endif

endmodule
